>>> sv/mpenc_pkg.sv
// Shared types and constants for the MessagePack value encoder.
// Holds the beat structs, the command codes and the format head bytes.
// No dependencies.
`default_nettype none

package mpenc_pkg;

	typedef enum logic [3:0] {
		CMD_RESTART = 4'd0,
		CMD_NIL     = 4'd1,
		CMD_BOOL    = 4'd2,
		CMD_UINT    = 4'd3,
		CMD_SINT    = 4'd4,
		CMD_FLOAT   = 4'd5,
		CMD_ARRAY   = 4'd6,
		CMD_MAP     = 4'd7,
		CMD_STR     = 4'd8,
		CMD_RAW     = 4'd9
	} cmd_t;

	localparam logic [7:0] HD_NIL    = 8'hc0;
	localparam logic [7:0] HD_FALSE  = 8'hc2;
	localparam logic [7:0] HD_TRUE   = 8'hc3;
	localparam logic [7:0] HD_FLOAT  = 8'hca;
	localparam logic [7:0] HD_U8     = 8'hcc;
	localparam logic [7:0] HD_U16    = 8'hcd;
	localparam logic [7:0] HD_U32    = 8'hce;
	localparam logic [7:0] HD_U64    = 8'hcf;
	localparam logic [7:0] HD_I8     = 8'hd0;
	localparam logic [7:0] HD_I16    = 8'hd1;
	localparam logic [7:0] HD_I32    = 8'hd2;
	localparam logic [7:0] HD_I64    = 8'hd3;
	localparam logic [7:0] HD_FIXARR = 8'h90;
	localparam logic [7:0] HD_ARR16  = 8'hdc;
	localparam logic [7:0] HD_ARR32  = 8'hdd;
	localparam logic [7:0] HD_FIXMAP = 8'h80;
	localparam logic [7:0] HD_MAP16  = 8'hde;
	localparam logic [7:0] HD_MAP32  = 8'hdf;
	localparam logic [7:0] HD_FIXSTR = 8'ha0;
	localparam logic [7:0] HD_STR8   = 8'hd9;
	localparam logic [7:0] HD_STR16  = 8'hda;

	localparam logic [15:0] CAPACITY_RESET = 16'd1024;

	typedef struct packed {
		logic [3:0]  command;
		logic [63:0] value;
	} in_beat_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        ok;
		logic [15:0] position;
		logic        last;
	} out_beat_t;

	// Decoded item: head byte, left-aligned big-endian payload, byte count.
	typedef struct packed {
		logic        restart;
		logic        emit;
		logic        refuse;
		logic [7:0]  head;
		logic [63:0] data;
		logic [3:0]  last_idx;
		logic [3:0]  total;
	} enc_t;

endpackage

`default_nettype wire

>>> sv/mpenc_decode.sv
// Combinational item decode: picks the shortest format, aligns the payload
// and checks the encoding against capacity. Depends on mpenc_pkg.
`default_nettype none

module mpenc_decode #(
	parameter int POSITION_BITS = 16
) (
	input  mpenc_pkg::in_beat_t     beat,
	input  logic [POSITION_BITS-1:0] pos,
	input  logic [15:0]             capacity,
	output mpenc_pkg::enc_t         enc
);
	import mpenc_pkg::*;

	localparam int SW = ((POSITION_BITS > 17) ? POSITION_BITS : 17) + 1;

	logic [63:0]   v;
	logic [63:0]   nv;
	logic [7:0]    head;
	logic [3:0]    nb;
	logic [15:0]   extra;
	logic          len_bad;
	logic          emit;
	logic          restart;
	logic [63:0]   data;
	logic [3:0]    total;
	logic [SW-1:0] need;
	logic          over;
	logic          ctr_small;
	logic          ctr_mid;
	logic          ctr_big;
	logic          ctr_map;

	assign v  = beat.value;
	assign nv = ~beat.value;

	assign ctr_small = (v[63:4] == '0);
	assign ctr_mid   = (v[63:16] == '0);
	assign ctr_big   = (v[63:32] == '0);
	assign ctr_map   = (cmd_t'(beat.command) == CMD_MAP);

	always_comb begin
		head    = '0;
		nb      = '0;
		extra   = '0;
		len_bad = 1'b0;
		emit    = 1'b1;
		restart = 1'b0;
		unique case (cmd_t'(beat.command))
			CMD_RESTART: begin
				emit    = 1'b0;
				restart = 1'b1;
			end
			CMD_NIL:   head = HD_NIL;
			CMD_BOOL:  head = (v != '0) ? HD_TRUE : HD_FALSE;
			CMD_UINT, CMD_SINT: begin
				if ((cmd_t'(beat.command) == CMD_SINT) && v[63]) begin
					priority if (nv[63:5] == '0) begin
						head = v[7:0];
					end else if (nv[63:7] == '0) begin
						head = HD_I8;
						nb   = 4'd1;
					end else if (nv[63:15] == '0) begin
						head = HD_I16;
						nb   = 4'd2;
					end else if (nv[63:31] == '0) begin
						head = HD_I32;
						nb   = 4'd4;
					end else begin
						head = HD_I64;
						nb   = 4'd8;
					end
				end else begin
					priority if (v[63:7] == '0) begin
						head = v[7:0];
					end else if (v[63:8] == '0) begin
						head = HD_U8;
						nb   = 4'd1;
					end else if (v[63:16] == '0) begin
						head = HD_U16;
						nb   = 4'd2;
					end else if (v[63:32] == '0) begin
						head = HD_U32;
						nb   = 4'd4;
					end else begin
						head = HD_U64;
						nb   = 4'd8;
					end
				end
			end
			CMD_FLOAT: begin
				head = HD_FLOAT;
				nb   = 4'd4;
			end
			CMD_ARRAY, CMD_MAP: begin
				priority if (ctr_small) begin
					head = (ctr_map ? HD_FIXMAP : HD_FIXARR) | {4'h0, v[3:0]};
				end else if (ctr_mid) begin
					head = ctr_map ? HD_MAP16 : HD_ARR16;
					nb   = 4'd2;
				end else if (ctr_big) begin
					head = ctr_map ? HD_MAP32 : HD_ARR32;
					nb   = 4'd4;
				end else begin
					len_bad = 1'b1;
				end
			end
			CMD_STR: begin
				extra = v[15:0];
				priority if (v[63:5] == '0) begin
					head = HD_FIXSTR | {3'b000, v[4:0]};
				end else if (v[63:8] == '0) begin
					head = HD_STR8;
					nb   = 4'd1;
				end else if (v[63:16] == '0) begin
					head = HD_STR16;
					nb   = 4'd2;
				end else begin
					len_bad = 1'b1;
				end
			end
			CMD_RAW:   head = v[7:0];
			default:   emit = 1'b0;
		endcase
	end

	always_comb begin
		unique case (nb)
			4'd1:    data = {v[7:0], 56'h0};
			4'd2:    data = {v[15:0], 48'h0};
			4'd4:    data = {v[31:0], 32'h0};
			4'd8:    data = v;
			default: data = '0;
		endcase
	end

	assign total = nb + 4'd1;
	assign need  = SW'(pos) + SW'(total) + SW'(extra);
	assign over  = need > SW'(capacity);

	always_comb begin
		enc.restart  = restart;
		enc.emit     = emit;
		enc.refuse   = emit && (len_bad || over);
		enc.head     = enc.refuse ? 8'h00 : head;
		enc.data     = data;
		enc.last_idx = enc.refuse ? 4'd0 : nb;
		enc.total    = total;
	end

endmodule

`default_nettype wire

>>> sv/msgpack_value_encoder.sv
// MessagePack value encoder top level: input register, decode, byte serializer.
// Depends on mpenc_pkg and mpenc_decode.
//
// Each accepted item is emitted as its shortest MessagePack encoding, one
// byte per output beat, most significant byte first, each tagged with its
// buffer offset. An item of n encoded bytes (1 to 9) holds the output byte
// serializer for n output beats, and a new item loads only as the last byte
// of the previous one goes out; a refused item gives one beat with ok low.
// Restart and unused commands give no beat and leave the input register
// without waiting for the serializer. An item passes the input register and
// the serializer register before its first byte is presented; the next item
// is decoded and accepted while the serializer still sends the previous one.
`default_nettype none

module msgpack_value_encoder #(
	parameter int POSITION_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mpenc_pkg::in_beat_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mpenc_pkg::out_beat_t out_data
);
	import mpenc_pkg::*;

	localparam int PW = (POSITION_BITS > 16) ? POSITION_BITS : 16;

	logic [15:0]              capacity_q;
	logic [POSITION_BITS-1:0] write_pos_q;
	logic                     in_valid_s1;
	in_beat_t                 in_s1;
	enc_t                     enc;
	logic                     busy_s2;
	logic [71:0]              sr_s2;
	logic [3:0]               cnt_s2;
	logic [POSITION_BITS-1:0] pos_s2;
	logic                     ok_s2;
	logic                     out_beat;
	logic                     ser_free;
	logic                     s1_take;
	logic                     load;
	logic [PW-1:0]            pos_ext;

	mpenc_decode #(
		.POSITION_BITS(POSITION_BITS)
	) u_decode (
		.beat    (in_s1),
		.pos     (write_pos_q),
		.capacity(capacity_q),
		.enc     (enc)
	);

	assign out_beat = busy_s2 && !out_stall;
	assign ser_free = !busy_s2 || (out_beat && (cnt_s2 == 4'd0));
	assign s1_take  = in_valid_s1 && (!enc.emit || ser_free);
	assign load     = s1_take && enc.emit;
	assign in_stall = in_valid_s1 && !s1_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			in_valid_s1 <= 1'b1;
		end else if (s1_take) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q <= '0;
		end else if (s1_take && enc.restart) begin
			write_pos_q <= '0;
		end else if (load && !enc.refuse) begin
			write_pos_q <= write_pos_q + POSITION_BITS'(enc.total);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s2 <= 1'b0;
		end else if (load) begin
			busy_s2 <= 1'b1;
		end else if (out_beat && (cnt_s2 == 4'd0)) begin
			busy_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sr_s2  <= {enc.head, enc.data};
			cnt_s2 <= enc.last_idx;
			pos_s2 <= write_pos_q;
			ok_s2  <= !enc.refuse;
		end else if (out_beat) begin
			sr_s2  <= {sr_s2[63:0], 8'h00};
			cnt_s2 <= cnt_s2 - 4'd1;
			pos_s2 <= pos_s2 + POSITION_BITS'(1);
		end
	end

	assign pos_ext   = PW'(pos_s2);
	assign out_valid = busy_s2;

	always_comb begin
		out_data.out_byte   = sr_s2[71:64];
		out_data.byte_valid = ok_s2;
		out_data.ok         = ok_s2;
		out_data.position   = pos_ext[15:0];
		out_data.last       = (cnt_s2 == 4'd0);
	end

`ifndef SYNTH
	a_refuse_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ok |-> out_data.last && (out_data.out_byte == 8'h00))
		else $error("refusal beat is not a single zero byte");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last |=>
			out_valid && (pos_s2 == $past(pos_s2) + POSITION_BITS'(1)))
		else $error("byte position did not advance within an item");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_take && enc.restart |=> write_pos_q == '0)
		else $error("restart did not clear write position");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> in_valid_s1 && enc.emit && busy_s2)
		else $error("input stalled without a pending item");
`endif

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for msgpack_value_encoder: directed and random value beats,
// predicted byte by byte and compared in order on the output channel.
// Depends on mpenc_pkg and the encoder RTL.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mpenc_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int RANDOM_ITEMS  = 72;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	in_beat_t    in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_beat_t   out_data;

	in_beat_t    pending_items [$];
	out_beat_t   expected_bytes [$];
	logic [15:0] cap_model  = CAPACITY_RESET;
	logic [15:0] wpos_model = '0;
	int          send_idle_pct = 0;
	int          stall_pct     = 0;
	bit          hold_req   = 1'b0;
	bit          hold_taken = 1'b0;
	int          hold_left  = 0;
	int          mismatch_count = 0;
	int          cycle_count    = 0;

	msgpack_value_encoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void encode_item(in_beat_t it);
		logic [63:0] v = it.value;
		logic [63:0] nv = ~it.value;
		logic [63:0] data = '0;
		logic [63:0] tmp;
		logic [7:0]  head = '0;
		int          nbytes = 0;
		int          extra = 0;
		int          i;
		bit          refused = 1'b0;
		bit          writes = 1'b1;
		bit          is_array = (it.command == CMD_ARRAY);
		out_beat_t   beat;
		case (it.command)
			CMD_RESTART: begin
				wpos_model = '0;
				writes = 1'b0;
			end
			CMD_NIL: head = HD_NIL;
			CMD_BOOL: head = (v != 64'd0) ? HD_TRUE : HD_FALSE;
			CMD_UINT, CMD_SINT: begin
				data = v;
				if (it.command == CMD_SINT && v[63]) begin
					if (nv < 64'd32) head = v[7:0];
					else if (nv < 64'd128) begin
						head = HD_I8;
						nbytes = 1;
					end else if (nv < 64'd32768) begin
						head = HD_I16;
						nbytes = 2;
					end else if (nv < 64'h8000_0000) begin
						head = HD_I32;
						nbytes = 4;
					end else begin
						head = HD_I64;
						nbytes = 8;
					end
				end else if (v <= 64'h7f) head = v[7:0];
				else if (v <= 64'hff) begin
					head = HD_U8;
					nbytes = 1;
				end else if (v <= 64'hffff) begin
					head = HD_U16;
					nbytes = 2;
				end else if (v <= 64'hffff_ffff) begin
					head = HD_U32;
					nbytes = 4;
				end else begin
					head = HD_U64;
					nbytes = 8;
				end
			end
			CMD_FLOAT: begin
				head = HD_FLOAT;
				data = {32'd0, v[31:0]};
				nbytes = 4;
			end
			CMD_ARRAY, CMD_MAP: begin
				data = v;
				if (v <= 64'd15) head = (is_array ? HD_FIXARR : HD_FIXMAP) | v[7:0];
				else if (v <= 64'hffff) begin
					head = is_array ? HD_ARR16 : HD_MAP16;
					nbytes = 2;
				end else if (v <= 64'hffff_ffff) begin
					head = is_array ? HD_ARR32 : HD_MAP32;
					nbytes = 4;
				end else refused = 1'b1;
			end
			CMD_STR: begin
				data = v;
				extra = int'(v[15:0]);
				if (v <= 64'd31) head = HD_FIXSTR | v[7:0];
				else if (v <= 64'hff) begin
					head = HD_STR8;
					nbytes = 1;
				end else if (v <= 64'hffff) begin
					head = HD_STR16;
					nbytes = 2;
				end else refused = 1'b1;
			end
			CMD_RAW: head = v[7:0];
			default: writes = 1'b0;
		endcase
		if (!writes) return;
		if (int'(wpos_model) + 1 + nbytes + extra > int'(cap_model)) refused = 1'b1;
		if (refused) begin
			beat.out_byte   = '0;
			beat.byte_valid = 1'b0;
			beat.ok         = 1'b0;
			beat.position   = wpos_model;
			beat.last       = 1'b1;
			expected_bytes.push_back(beat);
			return;
		end
		for (i = 0; i <= nbytes; i++) begin
			tmp = data >> (8 * (nbytes - i));
			beat.out_byte   = (i == 0) ? head : tmp[7:0];
			beat.byte_valid = 1'b1;
			beat.ok         = 1'b1;
			beat.position   = wpos_model;
			beat.last       = (i == nbytes);
			expected_bytes.push_back(beat);
			wpos_model = wpos_model + 16'd1;
		end
	endfunction

	task automatic flag_mismatch(string what, out_beat_t want, out_beat_t got);
		if (mismatch_count < 10)
			$display({"%t ERROR %s: exp byte=%02h vld=%0b ok=%0b pos=%0d last=%0b",
				" | got byte=%02h vld=%0b ok=%0b pos=%0d last=%0b"},
				$realtime, what,
				want.out_byte, want.byte_valid, want.ok, want.position, want.last,
				got.out_byte, got.byte_valid, got.ok, got.position, got.last);
		mismatch_count++;
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && !in_stall)
				encode_item(in_data);
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output backpressure, with a one-time long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left  <= HOLD_CYCLES;
			out_stall  <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// output monitor
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				flag_mismatch("unexpected beat", '0, out_data);
			end else begin
				want = expected_bytes.pop_front();
				if (out_data.out_byte !== want.out_byte || out_data.byte_valid !== want.byte_valid
						|| out_data.ok !== want.ok || out_data.position !== want.position
						|| out_data.last !== want.last)
					flag_mismatch("wrong beat", want, out_data);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", CYCLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic queue_item(logic [3:0] cmd, logic [63:0] v);
		in_beat_t it;
		it.command = cmd;
		it.value   = v;
		pending_items.push_back(it);
	endtask

	function automatic logic [63:0] edge_value();
		int          sh = 4;
		logic [63:0] p;
		logic [63:0] rnd = {$urandom, $urandom};
		case ($urandom_range(8))
			0: sh = 4;
			1: sh = 5;
			2: sh = 7;
			3: sh = 8;
			4: sh = 15;
			5: sh = 16;
			6: sh = 31;
			7: sh = 32;
			default: sh = 63;
		endcase
		p = 64'd1 << sh;
		case ($urandom_range(9))
			0, 1, 2: return rnd;
			3, 4: return 64'($urandom_range(300));
			5: return p - 64'd1;
			6: return p;
			7: return ~(p - 64'd1);
			8: return ~p;
			default: return rnd >> $urandom_range(63);
		endcase
	endfunction

	// Mostly well-formed strings and values, some restarts, junk commands, short payloads.
	task automatic queue_random(int n);
		int          count = 0;
		int          r;
		int          nraw;
		int          k;
		logic [63:0] len;
		logic [3:0]  cmd;
		while (count < n) begin
			r = $urandom_range(99);
			if (r < 5) begin
				queue_item(CMD_RESTART, {$urandom, $urandom});
				count++;
			end else if (r < 8) begin
				queue_item(4'($urandom_range(15, 10)), {$urandom, $urandom});
			end else if (r < 24) begin
				r = $urandom_range(9);
				if (r < 8) len = 64'($urandom_range(24));
				else if (r == 8) len = 64'($urandom_range(300, 25));
				else len = edge_value();
				nraw = (len <= 64'd300) ? int'(len) : $urandom_range(3);
				if ($urandom_range(9) == 0) nraw = $urandom_range(nraw);
				if (nraw > n - count - 1) nraw = n - count - 1;
				queue_item(CMD_STR, len);
				for (k = 0; k < nraw; k++)
					queue_item(CMD_RAW, {$urandom, $urandom});
				count += 1 + nraw;
			end else begin
				case ($urandom_range(7))
					0: cmd = CMD_NIL;
					1: cmd = CMD_BOOL;
					2: cmd = CMD_UINT;
					3: cmd = CMD_SINT;
					4: cmd = CMD_FLOAT;
					5: cmd = CMD_ARRAY;
					6: cmd = CMD_MAP;
					default: cmd = CMD_RAW;
				endcase
				queue_item(cmd, edge_value());
				count++;
			end
		end
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [15:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cap_model = v;
	endtask

	initial begin
		int          ph;
		logic [15:0] cap_value;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		queue_item(CMD_NIL, 64'd0);
		queue_item(CMD_BOOL, 64'd0);
		queue_item(CMD_BOOL, 64'h8000_0000_0000_0000);
		queue_item(CMD_UINT, 64'h7f);
		queue_item(CMD_UINT, 64'h80);
		queue_item(CMD_UINT, 64'hffff_ffff);
		queue_item(CMD_UINT, 64'hffff_ffff_ffff_ffff);
		queue_item(CMD_SINT, -64'sd32);
		queue_item(CMD_SINT, -64'sd33);
		queue_item(CMD_SINT, 64'h8000_0000_0000_0000);
		queue_item(CMD_SINT, 64'hffff_ffff_8000_0000);
		queue_item(CMD_SINT, 64'h7fff_ffff_ffff_ffff);
		queue_item(CMD_FLOAT, 64'hdead_beef_3f80_0000);
		queue_item(CMD_ARRAY, 64'd15);
		queue_item(CMD_ARRAY, 64'd16);
		queue_item(CMD_ARRAY, 64'h1_0000_0000);
		queue_item(CMD_MAP, 64'hffff);
		queue_item(CMD_MAP, 64'hffff_ffff);
		queue_item(CMD_STR, 64'd31);
		queue_item(CMD_STR, 64'h1_0000);
		queue_item(CMD_RAW, 64'hffff_ffff_ffff_ff5a);
		queue_item(4'hf, 64'hffff_ffff_ffff_ffff);
		queue_item(CMD_RESTART, 64'd0);
		queue_item(CMD_NIL, 64'd0);
		drain();

		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: cap_value = 16'hffff;
				1: cap_value = 16'd40;
				2: cap_value = 16'd0;
				3: cap_value = CAPACITY_RESET;
				4: cap_value = 16'($urandom_range(600));
				default: cap_value = 16'd12;
			endcase
			send_idle_pct = (ph % 4 == 1) ? 56 : (ph % 4 == 3) ? 20 : 0;
			stall_pct     = (ph % 4 == 2) ? 56 : (ph % 4 == 3) ? 20 : 0;
			write_capacity(cap_value);
			if (ph == 0) hold_req = 1'b1;
			queue_random(RANDOM_ITEMS);
			drain();
		end

		if (expected_bytes.size() != 0) begin
			$display("ERROR: %0d expected beats never arrived", expected_bytes.size());
			mismatch_count += expected_bytes.size();
		end
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
